>>> rtl/sla_pkg.sv
`timescale 1ns / 1ps
package sla_pkg;

  // result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ZERO    = 3'd1;
  localparam logic [2:0] ST_NOFIT   = 3'd2;
  localparam logic [2:0] ST_UNKNOWN = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  // request codes
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // shared unit operations
  localparam logic ALU_ADD = 1'b0;
  localparam logic ALU_SUB = 1'b1;

endpackage

>>> rtl/sla_ram.sv
`timescale 1ns / 1ps
module sla_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write one entry, register the read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/sla_alu.sv
`timescale 1ns / 1ps
module sla_alu
  import sla_pkg::*;
#(
  parameter int W = 17
) (
  input  logic         op,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W:0]   res,
  output logic         ge
);

  // add or subtract; the borrow gives a >= b
  always_comb begin
    if (op == ALU_SUB) begin
      res = {1'b0, a} - {1'b0, b};
    end else begin
      res = {1'b0, a} + {1'b0, b};
    end
    ge = ~res[W];
  end

endmodule

>>> rtl/segment_list_allocator.sv
`timescale 1ns / 1ps
// Channel  | Handshake          | Payload
// in       | in_valid/in_stall  | req_type, request_size, block_offset
// out      | out_valid/out_stall| granted_offset, status
// config   | pool_size_we       | pool_size
//
// An item scans the table through the single read port of the segment memory,
// and a split or merge then moves the entries behind the picked segment one by
// one. After reset or a pool_size write the S_INIT state rebuilds the table.
// in_stall is low only between items; a finished result waits in the output
// register and only the end of the next item waits on it.
module segment_list_allocator
  import sla_pkg::*;
#(
  parameter int MAX_SEGMENTS = 64,
  parameter int OFFSET_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        pool_size_we,
  input  logic [16:0] pool_size,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [16:0] request_size,
  input  logic [15:0] block_offset,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] granted_offset,
  output logic [2:0]  status
);

  localparam int OB   = OFFSET_BITS;
  localparam int LW   = OB + 1;
  localparam int CW   = (LW > 17) ? LW : 17;
  localparam int GW   = (OB > 16) ? OB : 16;
  localparam int EW   = 1 + OB + LW;
  localparam int IW   = $clog2(MAX_SEGMENTS);
  localparam int CNTW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [CW-1:0]   LIMIT_C    = CW'(1) << OB;
  localparam logic [CW-1:0]   POOL_RST_C = (LIMIT_C < CW'(65536)) ? LIMIT_C : CW'(65536);
  localparam logic [CNTW-1:0] MAX_C      = CNTW'(MAX_SEGMENTS);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_ADEC   = 4'd3;
  localparam logic [3:0] S_SHIFT  = 4'd4;
  localparam logic [3:0] S_SPLIT  = 4'd5;
  localparam logic [3:0] S_SPLIT2 = 4'd6;
  localparam logic [3:0] S_FM1    = 4'd7;
  localparam logic [3:0] S_FM2    = 4'd8;
  localparam logic [3:0] S_FW     = 4'd9;
  localparam logic [3:0] S_PACK   = 4'd10;
  localparam logic [3:0] S_RES    = 4'd11;

  logic [3:0]      state;
  logic [LW-1:0]   pool;
  logic [CNTW-1:0] count;
  logic [CNTW-1:0] ptr;
  logic            pend;
  logic [IW-1:0]   pidx;
  logic            op_free;
  logic [CW-1:0]   sz;
  logic [CW-1:0]   offs;
  logic            found;
  logic [IW-1:0]   pick;
  logic [OB-1:0]   pick_start;
  logic [LW-1:0]   rem;
  logic [OB-1:0]   cur_start;
  logic [LW-1:0]   cur_len;
  logic            last_used;
  logic [OB-1:0]   last_start;
  logic [LW-1:0]   last_len;
  logic            prev_used;
  logic [OB-1:0]   prev_start;
  logic [LW-1:0]   prev_len;
  logic            next_used;
  logic [LW-1:0]   next_len;
  logic [LW-1:0]   acc;
  logic [2:0]      res_status;
  logic [OB-1:0]   res_grant;

  logic            ram_we;
  logic [IW-1:0]   ram_waddr;
  logic [EW-1:0]   ram_wdata;
  logic [IW-1:0]   ram_raddr;
  logic [EW-1:0]   rdata;
  logic            r_used;
  logic [OB-1:0]   r_start;
  logic [LW-1:0]   r_len;

  logic            alu_op;
  logic [CW-1:0]   alu_a;
  logic [CW-1:0]   alu_b;
  logic [CW:0]     alu_res;
  logic            alu_ge;

  logic            mp;
  logic            mn;
  logic [1:0]      rcnt;
  logic [IW-1:0]   base;
  logic            issue;
  logic            out_load;
  logic [CW-1:0]   cfg_ext;
  logic [CW-1:0]   cfg_clamp;
  logic [GW-1:0]   grant_ext;

  function automatic logic idx_nz(input logic [IW-1:0] v);
    idx_nz = (v != '0);
  endfunction

  assign r_used  = rdata[EW-1];
  assign r_start = rdata[EW-2 -: OB];
  assign r_len   = rdata[LW-1:0];

  // merge decisions for a free
  assign mp   = (idx_nz(pick)) && !prev_used;
  assign mn   = ((CNTW'(pick) + CNTW'(1)) < count) && !next_used;
  assign rcnt = {1'b0, mp} + {1'b0, mn};
  assign base = pick - IW'(mp);

  // clamp a written pool size
  assign cfg_ext = CW'(pool_size);
  always_comb begin
    if (cfg_ext == '0) begin
      cfg_clamp = CW'(1);
    end else if (cfg_ext > LIMIT_C) begin
      cfg_clamp = LIMIT_C;
    end else begin
      cfg_clamp = cfg_ext;
    end
  end

  // read issue for scan and move passes
  always_comb begin
    case (state)
      S_SCAN:  issue = (ptr < count);
      S_SHIFT: issue = (ptr > CNTW'(pick));
      S_PACK:  issue = (ptr < count);
      default: issue = 1'b0;
    endcase
  end
  assign ram_raddr = ptr[IW-1:0];

  // steer the shared unit
  always_comb begin
    alu_op = ALU_ADD;
    alu_a  = '0;
    alu_b  = '0;
    case (state)
      S_SCAN: begin
        alu_op = ALU_SUB;
        alu_a  = CW'(r_len);
        alu_b  = sz;
      end
      S_SPLIT: begin
        alu_a = CW'(pick_start);
        alu_b = sz;
      end
      S_FM1: begin
        alu_a = CW'(cur_len);
        alu_b = mp ? CW'(prev_len) : '0;
      end
      S_FM2: begin
        alu_a = CW'(acc);
        alu_b = mn ? CW'(next_len) : '0;
      end
      default: begin
        alu_op = ALU_ADD;
      end
    endcase
  end

  sla_alu #(.W(CW)) u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .res(alu_res),
    .ge (alu_ge)
  );

  // memory write select
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    case (state)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = {1'b0, {OB{1'b0}}, pool};
      end
      S_ADEC: begin
        ram_we    = found && (rem == '0);
        ram_waddr = pick;
        ram_wdata = {1'b1, pick_start, sz[LW-1:0]};
      end
      S_SHIFT: begin
        ram_we    = pend;
        ram_waddr = pidx + IW'(1);
        ram_wdata = rdata;
      end
      S_SPLIT: begin
        ram_we    = 1'b1;
        ram_waddr = pick + IW'(1);
        ram_wdata = {1'b0, alu_res[OB-1:0], rem};
      end
      S_SPLIT2: begin
        ram_we    = 1'b1;
        ram_waddr = pick;
        ram_wdata = {1'b1, pick_start, sz[LW-1:0]};
      end
      S_FW: begin
        ram_we    = 1'b1;
        ram_waddr = base;
        ram_wdata = {1'b0, (mp ? prev_start : cur_start), acc};
      end
      S_PACK: begin
        ram_we    = pend;
        ram_waddr = pidx - IW'(rcnt);
        ram_wdata = rdata;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  sla_ram #(.WIDTH(EW), .DEPTH(MAX_SEGMENTS)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rdata)
  );

  assign in_stall  = (state != S_IDLE);
  assign grant_ext = GW'(res_grant);

  // load the output register once it is free or being taken
  assign out_load = (state == S_RES) && !pool_size_we && (!out_valid || !out_stall);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      pool      <= POOL_RST_C[LW-1:0];
      count     <= CNTW'(1);
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // load a new result or drop a taken one
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      // advance the read pointer
      pend <= issue;
      pidx <= ptr[IW-1:0];
      if (issue) begin
        ptr <= (state == S_SHIFT) ? ptr - CNTW'(1) : ptr + CNTW'(1);
      end

      if (pool_size_we) begin
        // a pool size write rebuilds the table
        pool  <= cfg_clamp[LW-1:0];
        state <= S_INIT;
      end else begin
        case (state)
          S_INIT: begin
            count <= CNTW'(1);
            state <= S_IDLE;
          end
          S_IDLE: begin
            if (in_valid) begin
              op_free <= (req_type == REQ_FREE);
              sz      <= CW'(request_size);
              offs    <= CW'(block_offset);
              found   <= 1'b0;
              ptr     <= '0;
              if (req_type == REQ_ALLOC && request_size == '0) begin
                res_status <= ST_ZERO;
                res_grant  <= '0;
                state      <= S_RES;
              end else begin
                state <= S_SCAN;
              end
            end
          end
          S_SCAN: begin
            if (pend) begin
              last_used  <= r_used;
              last_start <= r_start;
              last_len   <= r_len;
              if (!op_free) begin
                // keep the last free segment that fits
                if (!r_used && alu_ge) begin
                  found      <= 1'b1;
                  pick       <= pidx;
                  pick_start <= r_start;
                  rem        <= alu_res[LW-1:0];
                end
              end else if (!found && r_used && CW'(r_start) == offs) begin
                found      <= 1'b1;
                pick       <= pidx;
                cur_start  <= r_start;
                cur_len    <= r_len;
                prev_used  <= last_used;
                prev_start <= last_start;
                prev_len   <= last_len;
              end else if (found && pidx == pick + IW'(1)) begin
                next_used <= r_used;
                next_len  <= r_len;
              end
            end
            if (!issue && !pend) begin
              state <= op_free ? S_FM1 : S_ADEC;
            end
          end
          S_ADEC: begin
            res_grant <= '0;
            if (!found) begin
              res_status <= ST_NOFIT;
              state      <= S_RES;
            end else if (rem == '0) begin
              res_status <= ST_OK;
              res_grant  <= pick_start;
              state      <= S_RES;
            end else if (count == MAX_C) begin
              res_status <= ST_FULL;
              state      <= S_RES;
            end else begin
              ptr   <= count - CNTW'(1);
              state <= S_SHIFT;
            end
          end
          S_SHIFT: begin
            if (!issue && !pend) begin
              state <= S_SPLIT;
            end
          end
          S_SPLIT: begin
            state <= S_SPLIT2;
          end
          S_SPLIT2: begin
            count      <= count + CNTW'(1);
            res_status <= ST_OK;
            res_grant  <= pick_start;
            state      <= S_RES;
          end
          S_FM1: begin
            res_grant <= '0;
            if (!found) begin
              res_status <= ST_UNKNOWN;
              state      <= S_RES;
            end else begin
              acc   <= alu_res[LW-1:0];
              state <= S_FM2;
            end
          end
          S_FM2: begin
            acc   <= alu_res[LW-1:0];
            state <= S_FW;
          end
          S_FW: begin
            res_status <= ST_OK;
            if (rcnt == 2'd0) begin
              state <= S_RES;
            end else begin
              ptr   <= CNTW'(pick) + CNTW'(1) + CNTW'(mn);
              state <= S_PACK;
            end
          end
          S_PACK: begin
            if (!issue && !pend) begin
              count <= count - CNTW'(rcnt);
              state <= S_RES;
            end
          end
          S_RES: begin
            // hold until the output register is free
            if (out_load) begin
              status         <= res_status;
              granted_offset <= grant_ext[15:0];
              state          <= S_IDLE;
            end
          end
          default: begin
            state <= S_INIT;
          end
        endcase
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (state != S_INIT) |-> (count != '0 && count <= MAX_C))
    else $error("segment count out of range");

  a_split_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_SPLIT) |-> (count < MAX_C))
    else $error("split with a full table");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_RES))
    else $error("result loaded outside the result step");

  a_pack_merge: assert property (@(posedge clk) disable iff (rst)
    (state == S_PACK) |-> (rcnt != 2'd0))
    else $error("compaction without a merge");

endmodule
